[hw/rtl/bsbz_pkg.sv]
// Shared constants, types and latency helpers of the B-spline to Bezier converter.
`default_nettype none

package bsbz_pkg;

  localparam int COORD_WIDTH_DEF = 32;
  localparam int IDX_W           = 16;
  localparam int AXES            = 3;

  typedef enum logic [1:0] {
    SEL_END = 2'd0,
    SEL_M1  = 2'd1,
    SEL_M2  = 2'd2
  } res_sel_t;

  typedef struct packed {
    logic             vld;
    logic [IDX_W-1:0] idx;
    logic             shared;
    logic             last;
  } side_t;

  // The divider works on a magnitude of coord_w + 1 bits and needs one doubling add per stage.
  function automatic int div_stages(input int coord_w);
    return $clog2(coord_w + 2) - 1;
  endfunction

  function automatic int div_lat(input int coord_w);
    return div_stages(coord_w) + 2;
  endfunction

endpackage

`default_nettype wire

[hw/rtl/bsbz_in_if.sv]
// Control point channel between a source and the converter.
`default_nettype none

interface bsbz_in_if #(
  parameter int COORD_WIDTH = bsbz_pkg::COORD_WIDTH_DEF
);
  logic                          valid;
  logic                          ready;
  logic signed [COORD_WIDTH-1:0] in_x;
  logic signed [COORD_WIDTH-1:0] in_y;
  logic signed [COORD_WIDTH-1:0] in_z;
  logic                          final_point;

  modport source (output valid, in_x, in_y, in_z, final_point, input ready);
  modport sink   (input valid, in_x, in_y, in_z, final_point, output ready);
endinterface

`default_nettype wire

[hw/rtl/bsbz_out_if.sv]
// Bezier point channel between the converter and its sink.
`default_nettype none

interface bsbz_out_if #(
  parameter int COORD_WIDTH = bsbz_pkg::COORD_WIDTH_DEF
);
  logic                           valid;
  logic                           ready;
  logic signed [COORD_WIDTH-1:0]  out_x;
  logic signed [COORD_WIDTH-1:0]  out_y;
  logic signed [COORD_WIDTH-1:0]  out_z;
  logic [bsbz_pkg::IDX_W-1:0]     point_index;
  logic                           shared_endpoint;
  logic                           run_end;

  modport source (output valid, out_x, out_y, out_z, point_index, shared_endpoint, run_end,
                  input ready);
  modport sink   (input valid, out_x, out_y, out_z, point_index, shared_endpoint, run_end,
                  output ready);
endinterface

`default_nettype wire

[hw/rtl/bspline_to_bezier_points.sv]
// Top level of the cubic B-spline to Bezier point converter.
//
//   channel  direction  words                                   handshake
//   in_pt    input      in_x, in_y, in_z, final_point           valid/ready
//   out_pt   output     out_x, out_y, out_z, point_index,       valid/ready
//                       shared_endpoint, run_end
//
// One Bezier point leaves per cycle while out_pt.ready keeps the pipeline moving; a control point
// that yields three points holds the job slot until its third result has issued.
// The first result of an accepted word passes the job registers, the issue registers, the
// shift-add reciprocal divider chain and its quotient register, and then the output register.
// Synchronous reset clears the point counter, the index, the job slot and all valid bits.
// A low out_pt.ready stalls a valid output and the pipeline; a free job slot still takes input.
`default_nettype none

module bspline_to_bezier_points #(
  parameter int COORD_WIDTH = bsbz_pkg::COORD_WIDTH_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  bsbz_in_if.sink    in_pt,
  bsbz_out_if.source out_pt
);

  localparam int AX  = bsbz_pkg::AXES;
  localparam int NW  = COORD_WIDTH + 3;
  localparam int LAT = bsbz_pkg::div_lat(COORD_WIDTH);

  logic                          adv;
  logic signed [COORD_WIDTH-1:0] in_c [AX];
  logic signed [NW-1:0]          iss_n [AX];
  logic                          iss_d6;
  bsbz_pkg::side_t               iss_sb;
  logic [COORD_WIDTH-1:0]        quo [AX];
  logic                          neg [AX];
  bsbz_pkg::side_t               sb_r [LAT];
  logic                          out_v_r;
  logic [COORD_WIDTH-1:0]        oc_r [AX];
  logic [bsbz_pkg::IDX_W-1:0]    oidx_r;
  logic                          osh_r, olast_r;

  assign adv     = !out_v_r || out_pt.ready;
  assign in_c[0] = in_pt.in_x;
  assign in_c[1] = in_pt.in_y;
  assign in_c[2] = in_pt.in_z;

  bsbz_issue #(.COORD_WIDTH(COORD_WIDTH)) u_issue (
    .clk      (clk),
    .rst_n    (rst_n),
    .adv      (adv),
    .in_valid (in_pt.valid),
    .in_ready (in_pt.ready),
    .in_c     (in_c),
    .in_final (in_pt.final_point),
    .iss_n    (iss_n),
    .iss_d6   (iss_d6),
    .iss_sb   (iss_sb)
  );

  for (genvar a = 0; a < AX; a++) begin : g_lane
    bsbz_div #(.COORD_WIDTH(COORD_WIDTH)) u_div (
      .clk (clk),
      .en  (adv),
      .num (iss_n[a]),
      .d6  (iss_d6),
      .quo (quo[a]),
      .neg (neg[a])
    );
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < LAT; i++) begin
        sb_r[i] <= '0;
      end
      out_v_r <= 1'b0;
    end else if (adv) begin
      sb_r[0] <= iss_sb;
      for (int i = 1; i < LAT; i++) begin
        sb_r[i] <= sb_r[i-1];
      end
      out_v_r <= sb_r[LAT-1].vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int a = 0; a < AX; a++) begin
        oc_r[a] <= neg[a] ? (~quo[a] + COORD_WIDTH'(1)) : quo[a];
      end
      oidx_r  <= sb_r[LAT-1].idx;
      osh_r   <= sb_r[LAT-1].shared;
      olast_r <= sb_r[LAT-1].last;
    end
  end

  assign out_pt.valid           = out_v_r;
  assign out_pt.out_x           = oc_r[0];
  assign out_pt.out_y           = oc_r[1];
  assign out_pt.out_z           = oc_r[2];
  assign out_pt.point_index     = oidx_r;
  assign out_pt.shared_endpoint = osh_r;
  assign out_pt.run_end         = olast_r;

endmodule

`default_nettype wire

[hw/rtl/bsbz_issue.sv]
// Control point window, job register and per-result numerator issue stage.
`default_nettype none

module bsbz_issue #(
  parameter  int COORD_WIDTH = bsbz_pkg::COORD_WIDTH_DEF,
  localparam int NW          = COORD_WIDTH + 3
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          adv,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic signed [COORD_WIDTH-1:0] in_c [bsbz_pkg::AXES],
  input  logic                          in_final,
  output logic signed [NW-1:0]          iss_n [bsbz_pkg::AXES],
  output logic                          iss_d6,
  output bsbz_pkg::side_t               iss_sb
);

  localparam int AX = bsbz_pkg::AXES;
  localparam int IW = bsbz_pkg::IDX_W;

  logic signed [COORD_WIDTH-1:0] old_r [AX];
  logic signed [COORD_WIDTH-1:0] new_r [AX];
  logic signed [COORD_WIDTH-1:0] ja_r [AX];
  logic signed [COORD_WIDTH-1:0] jb_r [AX];
  logic signed [COORD_WIDTH-1:0] jc_r [AX];
  logic [1:0]                    seen_r, seen_nxt;
  logic [IW-1:0]                 nidx_r, nidx_nxt;
  logic [IW-1:0]                 jidx_r;
  logic                          job_v_r, job_v_nxt;
  logic                          job_one_r;
  bsbz_pkg::res_sel_t            jsel_r, jsel_nxt;
  logic                          acc, has3, has1, load, job_done, issue;
  logic [IW-1:0]                 cur_idx;
  logic signed [NW-1:0]          num [AX];
  logic signed [NW-1:0]          iss_n_r [AX];
  logic                          iss_v_r, iss_d6_r, iss_sh_r, iss_last_r;
  logic [IW-1:0]                 iss_idx_r;

  function automatic logic signed [NW-1:0] ext(input logic signed [COORD_WIDTH-1:0] v);
    return NW'(v);
  endfunction

  // Digits in base four sum to the same value modulo three.
  function automatic logic is_joint(input logic [IW-1:0] v);
    logic [4:0] s;
    logic [2:0] t;
    s = '0;
    for (int k = 0; k < IW / 2; k++) begin
      s = s + 5'(v[2*k +: 2]);
    end
    t = 3'(s[1:0]) + 3'(s[3:2]) + 3'(s[4]);
    return (v != '0) && (t == 3'd0 || t == 3'd3 || t == 3'd6);
  endfunction

  assign job_done = job_one_r || (jsel_r == bsbz_pkg::SEL_M2);
  assign issue    = adv && job_v_r;
  assign in_ready = !job_v_r || (issue && job_done);
  assign acc      = in_valid && in_ready;
  assign has3     = !in_final && (seen_r >= 2'd2);
  assign has1     = in_final && (seen_r == 2'd3);
  assign load     = acc && (has1 || has3);
  assign cur_idx  = jidx_r + IW'(jsel_r);

  always_comb begin
    seen_nxt = seen_r;
    nidx_nxt = nidx_r;
    if (acc) begin
      if (in_final) begin
        seen_nxt = '0;
        nidx_nxt = '0;
      end else begin
        if (seen_r != 2'd3) begin
          seen_nxt = seen_r + 2'd1;
        end
        if (has3) begin
          nidx_nxt = nidx_r + IW'(3);
        end
      end
    end
  end

  always_comb begin
    job_v_nxt = job_v_r;
    jsel_nxt  = jsel_r;
    if (issue) begin
      if (job_done) begin
        job_v_nxt = 1'b0;
      end else begin
        jsel_nxt = (jsel_r == bsbz_pkg::SEL_END) ? bsbz_pkg::SEL_M1 : bsbz_pkg::SEL_M2;
      end
    end
    if (load) begin
      job_v_nxt = 1'b1;
      jsel_nxt  = bsbz_pkg::SEL_END;
    end
  end

  always_comb begin
    for (int i = 0; i < AX; i++) begin
      unique case (jsel_r)
        bsbz_pkg::SEL_END: num[i] = ext(ja_r[i]) + (ext(jb_r[i]) <<< 2) + ext(jc_r[i]);
        bsbz_pkg::SEL_M1:  num[i] = (ext(jb_r[i]) <<< 1) + ext(jc_r[i]);
        bsbz_pkg::SEL_M2:  num[i] = ext(jb_r[i]) + (ext(jc_r[i]) <<< 1);
        default:           num[i] = '0;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seen_r  <= '0;
      nidx_r  <= '0;
      job_v_r <= 1'b0;
      jsel_r  <= bsbz_pkg::SEL_END;
      iss_v_r <= 1'b0;
    end else begin
      seen_r  <= seen_nxt;
      nidx_r  <= nidx_nxt;
      job_v_r <= job_v_nxt;
      jsel_r  <= jsel_nxt;
      if (adv) begin
        iss_v_r <= job_v_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (acc && !in_final) begin
      old_r <= new_r;
      new_r <= in_c;
    end
    if (load) begin
      ja_r      <= old_r;
      jb_r      <= new_r;
      jc_r      <= in_c;
      job_one_r <= in_final;
      jidx_r    <= nidx_r;
    end
    if (adv) begin
      iss_n_r    <= num;
      iss_d6_r   <= (jsel_r == bsbz_pkg::SEL_END);
      iss_idx_r  <= cur_idx;
      iss_sh_r   <= is_joint(cur_idx);
      iss_last_r <= job_done;
    end
  end

  assign iss_n         = iss_n_r;
  assign iss_d6        = iss_d6_r;
  assign iss_sb.vld    = iss_v_r;
  assign iss_sb.idx    = iss_idx_r;
  assign iss_sb.shared = iss_sh_r;
  assign iss_sb.last   = iss_last_r;

  a_final_restarts: assert property (@(posedge clk) disable iff (!rst_n)
    acc && in_final |=> seen_r == 2'd0 && nidx_r == '0)
    else $error("curve state not cleared after the final point");

  a_single_result: assert property (@(posedge clk) disable iff (!rst_n)
    job_v_r && job_one_r |-> jsel_r == bsbz_pkg::SEL_END)
    else $error("final point job advanced past its only result");

  a_job_holds: assert property (@(posedge clk) disable iff (!rst_n)
    job_v_r && !adv |=> job_v_r && $stable(jsel_r))
    else $error("job moved while the pipeline was stalled");

endmodule

`default_nettype wire

[hw/rtl/bsbz_div.sv]
// Pipelined round-to-nearest divider of one signed numerator by three or six.
`default_nettype none

module bsbz_div #(
  parameter  int COORD_WIDTH = bsbz_pkg::COORD_WIDTH_DEF,
  localparam int NW          = COORD_WIDTH + 3,
  localparam int UW          = COORD_WIDTH + 1,
  localparam int K           = bsbz_pkg::div_stages(COORD_WIDTH),
  localparam int S           = 1 << (K + 1),
  localparam int PW          = UW + S
) (
  input  logic                   clk,
  input  logic                   en,
  input  logic signed [NW-1:0]   num,
  input  logic                   d6,
  output logic [COORD_WIDTH-1:0] quo,
  output logic                   neg
);

  logic             n_neg;
  logic [NW-1:0]    flip;
  logic [2:0]       off;
  logic [NW-1:0]    mag;
  logic [UW-1:0]    u_nxt;
  logic [PW-1:0]    t_r [K+1];
  logic [UW-1:0]    u_r [K+1];
  logic             neg_r [K+2];
  logic [PW-1:0]    prod;
  logic [COORD_WIDTH-1:0] q_r;

  // The magnitude plus half the divisor; a negative value folds its two's complement one in.
  assign n_neg = num[NW-1];
  assign flip  = n_neg ? ~num : num;
  assign off   = d6 ? (n_neg ? 3'd4 : 3'd3) : (n_neg ? 3'd2 : 3'd1);
  assign mag   = flip + NW'(off);
  assign u_nxt = d6 ? UW'(mag >> 1) : UW'(mag);

  // Multiply by ceil(2^S / 3) as the product of (1 + 4^(2^g)) terms plus one more u.
  assign prod  = t_r[K] + PW'(u_r[K]);

  always_ff @(posedge clk) begin
    if (en) begin
      t_r[0]     <= PW'(u_nxt);
      u_r[0]     <= u_nxt;
      neg_r[0]   <= n_neg;
      q_r        <= prod[S +: COORD_WIDTH];
      neg_r[K+1] <= neg_r[K];
    end
  end

  for (genvar g = 0; g < K; g++) begin : g_step
    always_ff @(posedge clk) begin
      if (en) begin
        t_r[g+1]   <= t_r[g] + (t_r[g] << (2 << g));
        u_r[g+1]   <= u_r[g];
        neg_r[g+1] <= neg_r[g];
      end
    end
  end

  assign quo = q_r;
  assign neg = neg_r[K+1];

endmodule

`default_nettype wire

[sim/tb.sv]
// Self-checking testbench of the B-spline to Bezier point converter.
module tb;

  localparam int CW = bsbz_pkg::COORD_WIDTH_DEF;
  localparam int HALF_PERIOD = 6;
  localparam int LIMIT_CYCLES = 400000;
  localparam int HOLD_CYCLES = 200;
  localparam int MAX_PRINTS = 40;

  typedef logic signed [CW-1:0] coord_t;

  localparam coord_t MAXC = {1'b0, {(CW - 1){1'b1}}};
  localparam coord_t MINC = {1'b1, {(CW - 1){1'b0}}};

  typedef struct {
    coord_t      x;
    coord_t      y;
    coord_t      z;
    logic        fin;
    int unsigned phase;
  } ctl_point_t;

  typedef struct {
    coord_t                    x;
    coord_t                    y;
    coord_t                    z;
    logic [bsbz_pkg::IDX_W-1:0] idx;
    logic                      shared;
    logic                      last;
  } bez_point_t;

  logic clk;
  logic rst_n;

  bsbz_in_if  #(.COORD_WIDTH(CW)) in_pt ();
  bsbz_out_if #(.COORD_WIDTH(CW)) out_pt ();

  bspline_to_bezier_points #(.COORD_WIDTH(CW)) i_dut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_pt (in_pt),
    .out_pt(out_pt)
  );

  ctl_point_t point_feed [$];
  bez_point_t bezier_due [$];
  ctl_point_t next_word;
  bez_point_t want;

  coord_t                     win_old [3];
  coord_t                     win_new [3];
  int unsigned                win_count;
  logic [bsbz_pkg::IDX_W-1:0] idx_next;

  int unsigned bus_phase;
  int unsigned rx_phase;
  int unsigned points_taken;
  int unsigned pressure_at;
  int unsigned hold_left;
  int unsigned mismatches;

  always #(HALF_PERIOD) clk = ~clk;

  function automatic longint round_div(input longint n, input longint d);
    if (n >= 0) begin
      return (n + d / 2) / d;
    end
    return -((-n + d / 2) / d);
  endfunction

  function automatic coord_t rand_coord();
    case ($urandom_range(7))
      0: return MAXC;
      1: return MINC;
      2: return coord_t'($urandom_range(2)) - coord_t'(1);
      3: return coord_t'($urandom_range(2000)) - coord_t'(1000);
      default: return coord_t'($urandom);
    endcase
  endfunction

  task automatic add_point(input coord_t x, input coord_t y, input coord_t z, input logic fin,
                           input int unsigned phase);
    ctl_point_t p;
    p.x = x;
    p.y = y;
    p.z = z;
    p.fin = fin;
    p.phase = phase;
    point_feed = {point_feed, p};
  endtask

  task automatic push_bezier(input coord_t x, input coord_t y, input coord_t z,
                             input logic last);
    bez_point_t b;
    b.x = x;
    b.y = y;
    b.z = z;
    b.idx = idx_next;
    b.shared = (idx_next != 0) && (idx_next % 3 == 0);
    b.last = last;
    bezier_due = {bezier_due, b};
    idx_next = idx_next + 1'b1;
  endtask

  task automatic convert_point(input coord_t cx, input coord_t cy, input coord_t cz,
                               input logic fin);
    coord_t c [3];
    coord_t joint [3];
    coord_t third1 [3];
    coord_t third2 [3];
    c[0] = cx;
    c[1] = cy;
    c[2] = cz;
    for (int i = 0; i < 3; i++) begin
      joint[i] = coord_t'(round_div(longint'(win_old[i]) + 4 * longint'(win_new[i])
                                    + longint'(c[i]), 6));
      third1[i] = coord_t'(round_div(2 * longint'(win_new[i]) + longint'(c[i]), 3));
      third2[i] = coord_t'(round_div(longint'(win_new[i]) + 2 * longint'(c[i]), 3));
    end
    if (fin) begin
      if (win_count >= 3) begin
        push_bezier(joint[0], joint[1], joint[2], 1'b1);
      end
      for (int i = 0; i < 3; i++) begin
        win_old[i] = '0;
        win_new[i] = '0;
      end
      win_count = 0;
      idx_next = '0;
    end else begin
      if (win_count >= 2) begin
        push_bezier(joint[0], joint[1], joint[2], 1'b0);
        push_bezier(third1[0], third1[1], third1[2], 1'b0);
        push_bezier(third2[0], third2[1], third2[2], 1'b1);
      end
      for (int i = 0; i < 3; i++) begin
        win_old[i] = win_new[i];
        win_new[i] = c[i];
      end
      if (win_count < 3) begin
        win_count = win_count + 1;
      end
    end
  endtask

  task automatic flag_mismatch(input string msg);
    if (mismatches < MAX_PRINTS) begin
      $display("mismatch at %0t: %s", $realtime, msg);
    end
    mismatches = mismatches + 1;
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      in_pt.valid <= 1'b0;
    end else begin
      if (in_pt.valid && in_pt.ready) begin
        convert_point(in_pt.in_x, in_pt.in_y, in_pt.in_z, in_pt.final_point);
        points_taken <= points_taken + 1;
        rx_phase <= bus_phase;
      end
      if (!in_pt.valid || in_pt.ready) begin
        if (point_feed.size() != 0 && $urandom_range(99) >= (point_feed[0].phase == 0 ? 31 :
                                                              point_feed[0].phase == 1 ? 51 : 0))
        begin
          next_word = point_feed.pop_front();
          in_pt.valid <= 1'b1;
          in_pt.in_x <= next_word.x;
          in_pt.in_y <= next_word.y;
          in_pt.in_z <= next_word.z;
          in_pt.final_point <= next_word.fin;
          bus_phase <= next_word.phase;
        end else begin
          in_pt.valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      hold_left <= 0;
    end else if (in_pt.valid && in_pt.ready && points_taken == pressure_at) begin
      hold_left <= HOLD_CYCLES;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      out_pt.ready <= 1'b0;
    end else begin
      if (out_pt.valid && out_pt.ready) begin
        if (bezier_due.size() == 0) begin
          flag_mismatch($sformatf("unexpected Bezier word, index %0d", out_pt.point_index));
        end else begin
          want = bezier_due.pop_front();
          if (out_pt.out_x !== want.x)
            flag_mismatch($sformatf("index %0d x %0d, want %0d", want.idx, out_pt.out_x, want.x));
          if (out_pt.out_y !== want.y)
            flag_mismatch($sformatf("index %0d y %0d, want %0d", want.idx, out_pt.out_y, want.y));
          if (out_pt.out_z !== want.z)
            flag_mismatch($sformatf("index %0d z %0d, want %0d", want.idx, out_pt.out_z, want.z));
          if (out_pt.point_index !== want.idx)
            flag_mismatch($sformatf("point_index %0d, want %0d", out_pt.point_index, want.idx));
          if (out_pt.shared_endpoint !== want.shared)
            flag_mismatch($sformatf("index %0d shared_endpoint %0b, want %0b", want.idx,
                                    out_pt.shared_endpoint, want.shared));
          if (out_pt.run_end !== want.last)
            flag_mismatch($sformatf("index %0d run_end %0b, want %0b", want.idx,
                                    out_pt.run_end, want.last));
        end
      end
      out_pt.ready <= (hold_left == 0) && ($urandom_range(99) >= (rx_phase == 0 ? 51 :
                                                                   rx_phase == 1 ? 31 : 0));
    end
  end

  initial begin
    int unsigned added;
    int unsigned target;
    int unsigned len;
    clk = 1'b0;
    rst_n = 1'b0;
    in_pt.valid = 1'b0;
    in_pt.in_x = '0;
    in_pt.in_y = '0;
    in_pt.in_z = '0;
    in_pt.final_point = 1'b0;
    out_pt.ready = 1'b0;
    for (int i = 0; i < 3; i++) begin
      win_old[i] = '0;
      win_new[i] = '0;
    end
    win_count = 0;
    idx_next = '0;
    bus_phase = 0;
    rx_phase = 0;
    points_taken = 0;
    pressure_at = 0;
    mismatches = 0;

    // Curves too short to produce any point.
    add_point(MAXC, MINC, 1, 1'b1, 0);
    add_point(MINC, MAXC, -1, 1'b0, 0);
    add_point(MAXC, MAXC, MAXC, 1'b1, 0);
    add_point(5, -5, 0, 1'b0, 0);
    add_point(MAXC, MINC, 7, 1'b0, 0);
    add_point(MINC, MINC, MINC, 1'b1, 0);
    // Four-point curves at both ends of the range.
    add_point(MAXC, MINC, MAXC, 1'b0, 0);
    add_point(MAXC, MINC, MINC, 1'b0, 0);
    add_point(MAXC, MINC, MAXC, 1'b0, 0);
    add_point(MAXC, MINC, MINC, 1'b1, 0);
    // Rounding ties and small remainders of both signs.
    add_point(0, 0, 0, 1'b0, 0);
    add_point(0, 0, 0, 1'b0, 0);
    add_point(3, -3, 1, 1'b0, 0);
    add_point(-3, 3, -1, 1'b0, 0);
    add_point(1, -1, 2, 1'b0, 0);
    add_point(-1, 1, -2, 1'b0, 0);
    add_point(-2, 2, 3, 1'b1, 0);
    // Alternating extremes.
    add_point(MAXC, MINC, 0, 1'b0, 0);
    add_point(MINC, MAXC, -1, 1'b0, 0);
    add_point(MAXC, MINC, MAXC, 1'b0, 0);
    add_point(MINC, MAXC, MINC, 1'b0, 0);
    add_point(MAXC, MINC, -1, 1'b1, 0);

    for (int unsigned ph = 0; ph < 3; ph++) begin
      target = (ph == 2) ? 50 : 150;
      if (ph == 2) begin
        pressure_at = point_feed.size() + 8;
      end
      added = 0;
      while (added < target) begin
        len = ($urandom_range(9) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 12);
        for (int unsigned k = 0; k < len; k++) begin
          add_point(rand_coord(), rand_coord(), rand_coord(), k == len - 1, ph);
        end
        added = added + len;
      end
    end

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    while (point_feed.size() != 0 || in_pt.valid) @(posedge clk);
    while (bezier_due.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);

    if (mismatches == 0) begin
      $display("[bspline_to_bezier_points] OK");
    end else begin
      $display("[bspline_to_bezier_points] ERROR");
    end
    $finish;
  end

  initial begin
    #(2 * HALF_PERIOD * LIMIT_CYCLES);
    $display("timeout with %0d Bezier points outstanding", bezier_due.size());
    $display("[bspline_to_bezier_points] ERROR");
    $finish;
  end

endmodule

[filelist.f]
hw/rtl/bsbz_pkg.sv
hw/rtl/bsbz_in_if.sv
hw/rtl/bsbz_out_if.sv
hw/rtl/bsbz_issue.sv
hw/rtl/bsbz_div.sv
hw/rtl/bspline_to_bezier_points.sv
sim/tb.sv
